// ----- design/safs_pkg.sv -----
// Shared types, codes and defaults for the slot allocator with free stack.
package safs_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SLOT_W         = 8;
  localparam int BUS_W          = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_STACK_FULL = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_READ,
    OP_WRITE
  } op_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [SLOT_W-1:0] slot_index;
    logic [BUS_W-1:0]  data_in;
    logic              store_data;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [BUS_W-1:0]  data_out;
    logic [1:0]        status;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [BUS_W-1:0]  data;
    logic              store;
    logic              in_range;
  } cmd_t;

endpackage

// ----- design/safs_front.sv -----
// Front end: decodes a request and checks its index against the capacity.
module safs_front #(
  parameter int CAPACITY = safs_pkg::CAPACITY_DEF
) (
  input  safs_pkg::in_t  req,
  output safs_pkg::cmd_t cmd
);
  import safs_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;

  always_comb begin
    case (req.action)
      ACT_ADD:    cmd.op = OP_ADD;
      ACT_REMOVE: cmd.op = OP_REMOVE;
      ACT_READ:   cmd.op = OP_READ;
      ACT_WRITE:  cmd.op = OP_WRITE;
      default:    cmd.op = OP_ADD;
    endcase
    cmd.slot     = req.slot_index;
    cmd.data     = req.data_in;
    cmd.store    = req.store_data;
    cmd.in_range = IW'(req.slot_index) < IW'(CAPACITY);
  end

endmodule

// ----- design/safs_fifo.sv -----
// Small register queue used between the front, the back and the result port.
module safs_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  T     wr_data,
  input  logic pop,
  output logic empty,
  output T     rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  T                mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == NW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- design/safs_back.sv -----
// Back end: free stack, bump cursor and element store; executes one command at a time.
module safs_back #(
  parameter int CAPACITY   = safs_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = safs_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  safs_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output safs_pkg::out_t res
);
  import safs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_e;

  state_e state;
  state_e state_next;

  logic [CW-1:0] free_count;
  logic [CW-1:0] free_count_next;
  logic [CW-1:0] next_fresh;
  logic [CW-1:0] next_fresh_next;

  // held across the memory read
  logic              hold_is_add;
  logic [SLOT_W-1:0] hold_slot;
  logic [BUS_W-1:0]  hold_data;
  logic              hold_store;
  logic              start;
  logic              go_wait;

  logic [DATA_WIDTH-1:0] el_mem [CAPACITY];
  logic                  el_we;
  logic [AW-1:0]         el_waddr;
  logic [DATA_WIDTH-1:0] el_wdata;
  logic                  el_re;
  logic [AW-1:0]         el_raddr;
  logic [DATA_WIDTH-1:0] el_rd;

  logic [SLOT_W-1:0] stk_mem [CAPACITY];
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic              stk_re;
  logic [AW-1:0]     stk_raddr;
  logic [SLOT_W-1:0] stk_rd;

  assign start   = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop = start;

  always_comb begin
    state_next      = state;
    free_count_next = free_count;
    next_fresh_next = next_fresh;
    go_wait         = 1'b0;
    res_push        = 1'b0;
    res.slot_out    = cmd.slot;
    res.data_out    = '0;
    res.status      = ST_OK;
    el_we           = 1'b0;
    el_waddr        = AW'(cmd.slot);
    el_wdata        = DATA_WIDTH'(cmd.data);
    el_re           = 1'b0;
    el_raddr        = AW'(cmd.slot);
    stk_we          = 1'b0;
    stk_waddr       = free_count[AW-1:0];
    stk_re          = 1'b0;
    stk_raddr       = AW'(free_count - 1'b1);

    if (state == S_WAIT) begin
      res_push    = 1'b1;
      state_next  = S_IDLE;
      if (hold_is_add) begin
        res.slot_out = stk_rd;
        el_we        = hold_store;
        el_waddr     = AW'(stk_rd);
        el_wdata     = DATA_WIDTH'(hold_data);
      end else begin
        res.slot_out = hold_slot;
        res.data_out = BUS_W'(el_rd);
      end
    end else if (start) begin
      case (cmd.op)
        OP_ADD: begin
          if (free_count != '0) begin
            stk_re          = 1'b1;
            free_count_next = free_count - 1'b1;
            go_wait         = 1'b1;
          end else if (next_fresh < CW'(CAPACITY)) begin
            next_fresh_next = next_fresh + 1'b1;
            res.slot_out    = SLOT_W'(next_fresh);
            el_we           = cmd.store;
            el_waddr        = next_fresh[AW-1:0];
          end else begin
            res.slot_out = '0;
            res.status   = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (IW'(cmd.slot) >= IW'(next_fresh)) begin
            res.status = ST_RANGE;
          end else if (free_count == CW'(CAPACITY)) begin
            res.status = ST_STACK_FULL;
          end else begin
            stk_we          = 1'b1;
            free_count_next = free_count + 1'b1;
          end
        end
        OP_READ: begin
          if (cmd.in_range) begin
            el_re   = 1'b1;
            go_wait = 1'b1;
          end else begin
            res.status = ST_RANGE;
          end
        end
        OP_WRITE: begin
          if (cmd.in_range) begin
            el_we = 1'b1;
          end else begin
            res.status = ST_RANGE;
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
      res_push = !go_wait;
      if (go_wait) begin
        state_next = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      next_fresh <= '0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      next_fresh <= next_fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hold_is_add <= cmd.op == OP_ADD;
      hold_slot   <= cmd.slot;
      hold_data   <= cmd.data;
      hold_store  <= cmd.store;
    end
  end

  always_ff @(posedge clk) begin
    if (el_we) begin
      el_mem[el_waddr] <= el_wdata;
    end
    if (el_re) begin
      el_rd <= el_mem[el_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= cmd.slot;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

endmodule

// ----- design/slot_allocator_free_stack.sv -----
// Top level of the slot allocator: front decode, command queue, back end, result queue.
//
// Requests enter through push/full and are accepted at an edge with push high and
// full low. Each request yields exactly one result, delivered in request order
// through empty/pop: the oldest result sits on the result port while empty is low
// and leaves at an edge with pop high.
// Results: for a write, a remove, a fresh-slot add or any rejected request the back end
// pushes the result into the result queue as it takes the command from the command queue;
// a read and an add served from the free stack pass through the back end's wait state.
// Throughput: one request per cycle for the kinds that skip the wait state, while the
// result queue is not full; a read or a stack-served add holds the back end busy in its
// wait state for the registered read port of the element store and of the free stack.
// Reset clears the free count, the bump cursor and both queues; the element store
// and the free stack are not cleared. A stalled receiver fills the two-entry result
// queue, the back end then halts, the two-entry command queue fills and full rises.
module slot_allocator_free_stack #(
  parameter int CAPACITY   = safs_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = safs_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  safs_pkg::in_t  req,
  output logic           empty,
  input  logic           pop,
  output safs_pkg::out_t result
);
  import safs_pkg::*;

  cmd_t front_cmd;
  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  out_t res;

  safs_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .req(req),
    .cmd(front_cmd)
  );

  safs_fifo #(
    .T(cmd_t),
    .DEPTH(2)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .wr_data(front_cmd),
    .pop(cmd_pop),
    .empty(cmd_empty),
    .rd_data(cmd)
  );

  safs_back #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .cmd_valid(!cmd_empty),
    .cmd_pop(cmd_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res(res)
  );

  safs_fifo #(
    .T(out_t),
    .DEPTH(2)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .full(res_full),
    .wr_data(res),
    .pop(pop),
    .empty(empty),
    .rd_data(result)
  );

endmodule

// ----- sim/slot_allocator_free_stack_checker.sv -----
// Checker for the slot allocator: predicts one result per request and compares them in order.
module slot_allocator_free_stack_checker
  import safs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  in_t  req,
  input  logic empty,
  input  logic pop,
  input  out_t result,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;

  logic [BUS_W-1:0]  elements   [CAP];
  logic [SLOT_W-1:0] free_slots [CAP];
  logic [8:0]        free_cnt;
  logic [8:0]        cursor;
  out_t              expected_results [$];

  function automatic out_t apply_request(in_t r);
    out_t             o;
    logic [SLOT_W-1:0] got;
    logic             have;
    o.slot_out = r.slot_index;
    o.data_out = '0;
    o.status   = ST_OK;
    case (op_e'(r.action))
      OP_ADD: begin
        have = 1'b1;
        // freed slots first, newest on top; fresh slots only once the stack is empty
        if (free_cnt != 0) begin
          free_cnt = free_cnt - 1'b1;
          got      = free_slots[free_cnt[SLOT_W-1:0]];
        end else if (cursor < CAP) begin
          got    = cursor[SLOT_W-1:0];
          cursor = cursor + 1'b1;
        end else begin
          got  = '0;
          have = 1'b0;
        end
        if (have) begin
          if (r.store_data) elements[got] = r.data_in;
          o.slot_out = got;
        end else begin
          o.slot_out = '0;
          o.status   = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if ({1'b0, r.slot_index} >= cursor) begin
          o.status = ST_RANGE;
        end else if (free_cnt >= CAP) begin
          o.status = ST_STACK_FULL;
        end else begin
          free_slots[free_cnt[SLOT_W-1:0]] = r.slot_index;
          free_cnt                         = free_cnt + 1'b1;
        end
      end
      OP_READ: begin
        if (r.slot_index < CAP) o.data_out = elements[r.slot_index];
        else o.status = ST_RANGE;
      end
      default: begin
        if (r.slot_index < CAP) elements[r.slot_index] = r.data_in;
        else o.status = ST_RANGE;
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      free_cnt = '0;
      cursor   = '0;
      expected_results.delete();
    end else begin
      // a result leaving now can never belong to the request entering now
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: slot_out %0d data_out %h status %0d",
                 result.slot_out, result.data_out, result.status);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (result.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, got %0d", want.slot_out, result.slot_out);
            fails++;
          end
          if (result.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, result.data_out);
            fails++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fails++;
          end
        end
      end
      if (push && !full) expected_results.push_back(apply_request(req));
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/slot_allocator_free_stack_test.sv -----
// Testbench top for the slot allocator: clock, reset, request stimulus and verdict.
module slot_allocator_free_stack_test;
  timeunit 1ns;
  timeprecision 1ps;

  import safs_pkg::*;

  typedef enum {MODE_MIX, MODE_FILL, MODE_FREE} gen_mode_e;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst  = 1'b1;
  logic push = 1'b0;
  logic pop  = 1'b0;
  logic full;
  logic empty;
  in_t  req  = '0;
  out_t result;
  int   fails;
  int   leftover;

  // what is known so far: slots the block handed out and slots holding data
  in_t               in_flight [$];
  bit                issued  [256];
  bit                written [256];
  logic [SLOT_W-1:0] issued_slots  [$];
  logic [SLOT_W-1:0] written_slots [$];
  int                full_seen;
  bit                calm = 1'b0;
  int                cycles;
  int                guard;

  slot_allocator_free_stack dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req    (req),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  slot_allocator_free_stack_checker chk (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .fails   (fails),
    .pending (leftover)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 30);
  end

  task automatic note_written(logic [SLOT_W-1:0] s);
    if (!written[s]) begin
      written[s] = 1'b1;
      written_slots.push_back(s);
    end
  endtask

  task automatic note_issued(logic [SLOT_W-1:0] s);
    if (!issued[s]) begin
      issued[s] = 1'b1;
      issued_slots.push_back(s);
    end
  endtask

  // Sampled at the falling edge: pop, empty and result are stable and show what the
  // next rising edge takes.
  always @(negedge clk) begin
    in_t r;
    if (!rst && pop && !empty && in_flight.size() != 0) begin
      r = in_flight.pop_front();
      if (r.action == ACT_ADD) begin
        if (result.status == ST_OK) begin
          note_issued(result.slot_out);
          if (r.store_data) note_written(result.slot_out);
        end else begin
          full_seen++;
        end
      end
    end
  end

  function automatic in_t pack_request(logic [1:0] action, logic [SLOT_W-1:0] slot,
                                       logic [BUS_W-1:0] data, logic store);
    in_t r;
    r.action     = action;
    r.slot_index = slot;
    r.data_in    = data;
    r.store_data = store;
    return r;
  endfunction

  function automatic in_t make_request(gen_mode_e mode);
    in_t r;
    int  pick;
    r = pack_request(ACT_ADD, SLOT_W'($urandom), $urandom, 1'($urandom_range(1)));
    if ($urandom_range(9) == 0) r.data_in = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(99);
    case (mode)
      MODE_MIX: begin
        if (pick < 30) r.action = ACT_ADD;
        else if (pick < 55) r.action = ACT_REMOVE;
        else if (pick < 80) r.action = ACT_READ;
        else r.action = ACT_WRITE;
      end
      MODE_FILL: begin
        if (pick < 96) r.action = ACT_ADD;
        else if (pick < 98) r.action = ACT_READ;
        else r.action = ACT_WRITE;
      end
      default: begin
        r.action = ACT_REMOVE;
      end
    endcase
    // mostly free slots that were handed out; the rest pick a random slot, some out of range
    if (r.action == ACT_REMOVE && issued_slots.size() != 0 && $urandom_range(99) < 85)
      r.slot_index = issued_slots[$urandom_range(issued_slots.size() - 1)];
    if (r.action == ACT_WRITE && issued_slots.size() != 0 && $urandom_range(1))
      r.slot_index = issued_slots[$urandom_range(issued_slots.size() - 1)];
    // reads only go to slots known to hold data
    if (r.action == ACT_READ) begin
      if (written_slots.size() == 0) r.action = ACT_WRITE;
      else r.slot_index = written_slots[$urandom_range(written_slots.size() - 1)];
    end
    return r;
  endfunction

  task automatic send(in_t r);
    push <= 1'b1;
    req  <= r;
    if (r.action == ACT_WRITE) note_written(r.slot_index);
    @(posedge clk);
    while (full) @(posedge clk);
    in_flight.push_back(r);
    if (!calm && $urandom_range(99) < 30) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic wait_results;
    push <= 1'b0;
    while (in_flight.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty allocator, stack reuse, double free, range errors, data extremes
    send(pack_request(ACT_REMOVE, 8'd0, 32'h0, 1'b0));
    send(pack_request(ACT_ADD, 8'd255, 32'hffff_ffff, 1'b1));
    send(pack_request(ACT_ADD, 8'd0, 32'h0, 1'b0));
    send(pack_request(ACT_WRITE, 8'd255, 32'h0, 1'b1));
    send(pack_request(ACT_WRITE, 8'd1, 32'h8000_0001, 1'b0));
    send(pack_request(ACT_READ, 8'd255, 32'hffff_ffff, 1'b1));
    send(pack_request(ACT_READ, 8'd0, 32'h0, 1'b0));
    send(pack_request(ACT_READ, 8'd1, 32'h0, 1'b0));
    send(pack_request(ACT_REMOVE, 8'd1, 32'h0, 1'b0));
    send(pack_request(ACT_REMOVE, 8'd1, 32'hffff_ffff, 1'b1));
    send(pack_request(ACT_REMOVE, 8'd200, 32'h0, 1'b0));
    send(pack_request(ACT_ADD, 8'd0, 32'h5a5a_a5a5, 1'b1));
    send(pack_request(ACT_ADD, 8'd0, 32'h0, 1'b0));
    send(pack_request(ACT_READ, 8'd1, 32'h0, 1'b0));
    send(pack_request(ACT_REMOVE, 8'd2, 32'h0, 1'b0));
    send(pack_request(ACT_ADD, 8'd7, 32'hffff_ffff, 1'b1));
    send(pack_request(ACT_READ, 8'd2, 32'h0, 1'b0));

    repeat (12) send(make_request(MODE_MIX));

    // run the cursor to the end with no idling on either side
    calm  <= 1'b1;
    guard  = 0;
    while (full_seen < 3 && guard < 400) begin
      send(make_request(MODE_FILL));
      guard++;
    end
    calm <= 1'b0;
    wait_results();

    // every slot is issued now: free past the stack's capacity
    repeat (260) send(make_request(MODE_FREE));
    repeat (12) send(make_request(MODE_MIX));

    wait_results();
    repeat (20) @(posedge clk);
    if (leftover != 0) $error("%0d expected results never arrived", leftover);
    if (fails == 0 && leftover == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
